[src/kmac_pkg.sv]
package kmac_pkg;

  localparam int unsigned DIMS_DEF       = 8;
  localparam int unsigned CENTERS_DEF    = 16;
  localparam int unsigned MAX_POINTS_DEF = 16384;
  localparam int unsigned COORD_BITS_DEF = 10;

  localparam int unsigned FRAC      = 6;
  localparam int unsigned CW        = 16;   // Q10.6 centre coordinate
  localparam int unsigned SUMW      = 24;
  localparam int unsigned CNTW      = 15;
  localparam int unsigned MEASW     = 35;
  localparam int unsigned IDW       = 4;
  localparam int unsigned INW       = 10;
  localparam int unsigned KINDW     = 2;
  localparam int unsigned NOUT_DIMS = 8;
  localparam int unsigned QW        = 32;   // quotient width of the divider
  localparam int unsigned SQW       = 32;   // one squared difference
  localparam int unsigned ACCW      = 36;   // sum of eight squares

  localparam logic [KINDW-1:0] KIND_LOAD     = 2'd0;
  localparam logic [KINDW-1:0] KIND_CLASSIFY = 2'd1;
  localparam logic [KINDW-1:0] KIND_RECENTER = 2'd2;

  localparam logic [MEASW-1:0] MEAS_MAX = {MEASW{1'b1}};

  // ripple token handed along the row of cells
  typedef struct packed {
    logic             vld;
    logic [MEASW-1:0] best;
    logic [IDW-1:0]   idx;
  } kmac_tok_t;

endpackage

[src/kmac_cell.sv]
// One centre: holds its coordinates, sums and count. Compares the point
// passed in against its own centre and forwards the better candidate.
module kmac_cell #(
  parameter int unsigned DIMS       = kmac_pkg::DIMS_DEF,
  parameter int unsigned MAX_POINTS = kmac_pkg::MAX_POINTS_DEF,
  parameter int unsigned MY_ID      = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic                                 add_i,
  input  logic                                 upd_i,
  input  logic                                 clr_i,
  input  logic [DIMS-1:0][kmac_pkg::CW-1:0]    new_i,
  input  logic [DIMS-1:0][kmac_pkg::CW-1:0]    pt_i,
  input  logic [DIMS-1:0][kmac_pkg::INW-1:0]   raw_i,
  input  logic                                 tok_en_i,
  input  kmac_pkg::kmac_tok_t                  tok_i,
  output kmac_pkg::kmac_tok_t                  tok_o,
  output logic [DIMS-1:0][kmac_pkg::CW-1:0]    ctr_o,
  output logic [DIMS-1:0][kmac_pkg::SUMW-1:0]  sum_o,
  output logic [kmac_pkg::CNTW-1:0]            cnt_o
);
  logic [DIMS-1:0][kmac_pkg::CW-1:0]   ctr_q;
  logic [DIMS-1:0][kmac_pkg::SUMW-1:0] sum_q;
  logic [kmac_pkg::CNTW-1:0]           cnt_q;
  logic [DIMS-1:0][kmac_pkg::SQW-1:0]  sq_q;
  kmac_pkg::kmac_tok_t                 tok_q;
  logic [kmac_pkg::ACCW-1:0]           acc;
  logic [kmac_pkg::MEASW-1:0]          gap;
  logic                                full;

  assign full = (32'(cnt_q) >= MAX_POINTS);

  // stage 1: squares per dimension
  always_ff @(posedge clk_i) begin
    for (int d = 0; d < DIMS; d++) begin
      sq_q[d] <= (pt_i[d] > ctr_q[d]) ?
        32'(pt_i[d] - ctr_q[d]) * 32'(pt_i[d] - ctr_q[d]) :
        32'(ctr_q[d] - pt_i[d]) * 32'(ctr_q[d] - pt_i[d]);
    end
  end

  always_comb begin
    acc = '0;
    for (int d = 0; d < DIMS; d++) acc = acc + kmac_pkg::ACCW'(sq_q[d]);
    gap = (acc > kmac_pkg::ACCW'(kmac_pkg::MEAS_MAX)) ? kmac_pkg::MEAS_MAX
                                                      : acc[kmac_pkg::MEASW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      if (tok_en_i) begin
        if (tok_i.vld && (MY_ID == 0 || gap < tok_i.best)) begin
          tok_q.vld  <= 1'b1;
          tok_q.best <= gap;
          tok_q.idx  <= kmac_pkg::IDW'(MY_ID);
        end else begin
          tok_q <= tok_i;
        end
      end
      if (clr_i) begin
        cnt_q <= '0;
        sum_q <= '0;
      end else if (add_i && !full) begin
        cnt_q <= cnt_q + 1'b1;
        for (int d = 0; d < DIMS; d++) begin
          sum_q[d] <= ((25'(sum_q[d]) + 25'(raw_i[d])) > 25'({kmac_pkg::SUMW{1'b1}})) ?
                      {kmac_pkg::SUMW{1'b1}} : sum_q[d] + kmac_pkg::SUMW'(raw_i[d]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i || upd_i) ctr_q <= new_i;
  end

  assign tok_o = tok_q;
  assign ctr_o = ctr_q;
  assign sum_o = sum_q;
  assign cnt_o = cnt_q;
endmodule

[src/kmac_div.sv]
// Restoring divider, one quotient bit a cycle.
module kmac_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [kmac_pkg::QW-1:0]       num_i,
  input  logic [kmac_pkg::CNTW-1:0]     den_i,
  output logic                          done_o,
  output logic [kmac_pkg::QW-1:0]       quo_o
);
  logic [kmac_pkg::QW-1:0]   q_q;
  logic [kmac_pkg::CNTW:0]   r_q;
  logic [kmac_pkg::CNTW-1:0] den_q;
  logic [5:0]                n_q;
  logic                      busy_q;
  logic [kmac_pkg::CNTW+1:0] t;

  assign t = {r_q, q_q[kmac_pkg::QW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        n_q    <= 6'(kmac_pkg::QW);
      end else if (busy_q) begin
        n_q <= n_q - 1'b1;
        if (n_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (t >= (kmac_pkg::CNTW+2)'(den_q)) begin
        r_q <= (kmac_pkg::CNTW+1)'(t - (kmac_pkg::CNTW+2)'(den_q));
        q_q <= {q_q[kmac_pkg::QW-2:0], 1'b1};
      end else begin
        r_q <= t[kmac_pkg::CNTW:0];
        q_q <= {q_q[kmac_pkg::QW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = q_q;
endmodule

[src/kmeans_assign_and_recenter_core.sv]
// Channel | dir | handshake        | payload
// in      | in  | in_valid/ready   | kind, center_slot, coord_0..7
// out     | out | out_valid/ready  | center_id, measure, member_count, last,
//         |     |                  | out_coord_0..7
//
// Load writes the named slot's centre. Classify: token ripples a cell a cycle.
// Recenter: per non-empty centre one division per dimension on the shared
// divider; an empty centre skips the divider.
// Reset clears counts, sums and control; centres are undefined until loaded.
// A stalled result holds the block; no request is taken until all results have left.
module kmeans_assign_and_recenter_core #(
  parameter int unsigned DIMS       = kmac_pkg::DIMS_DEF,
  parameter int unsigned CENTERS    = kmac_pkg::CENTERS_DEF,
  parameter int unsigned MAX_POINTS = kmac_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = kmac_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  center_slot_i,
  input  logic [9:0]  coord_0_i,
  input  logic [9:0]  coord_1_i,
  input  logic [9:0]  coord_2_i,
  input  logic [9:0]  coord_3_i,
  input  logic [9:0]  coord_4_i,
  input  logic [9:0]  coord_5_i,
  input  logic [9:0]  coord_6_i,
  input  logic [9:0]  coord_7_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  center_id_o,
  output logic [34:0] measure_o,
  output logic [14:0] member_count_o,
  output logic        last_o,
  output logic [15:0] out_coord_0_o,
  output logic [15:0] out_coord_1_o,
  output logic [15:0] out_coord_2_o,
  output logic [15:0] out_coord_3_o,
  output logic [15:0] out_coord_4_o,
  output logic [15:0] out_coord_5_o,
  output logic [15:0] out_coord_6_o,
  output logic [15:0] out_coord_7_o
);
  localparam int unsigned CW   = kmac_pkg::CW;
  localparam int unsigned DIW  = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int unsigned CIW  = $clog2(CENTERS);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CLS  = 9'b000000010,
    S_ADD  = 9'b000000100,
    S_EMIT = 9'b000001000,
    S_RDIV = 9'b000010000,
    S_RWT  = 9'b000100000,
    S_RSQ  = 9'b001000000,
    S_RSUM = 9'b010000000,
    S_RUPD = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // widen a centre to the eight coordinate ports, unused ones zero
  function automatic logic [kmac_pkg::NOUT_DIMS-1:0][CW-1:0] pad_coords(
      input logic [DIMS-1:0][CW-1:0] v);
    logic [kmac_pkg::NOUT_DIMS-1:0][CW-1:0] r;
    r = '0;
    for (int d = 0; d < DIMS; d++) r[d] = v[d];
    return r;
  endfunction

  logic [7:0][9:0] raw_in;
  assign raw_in = {coord_7_i, coord_6_i, coord_5_i, coord_4_i,
                   coord_3_i, coord_2_i, coord_1_i, coord_0_i};

  logic [DIMS-1:0][kmac_pkg::INW-1:0] raw_q;
  logic [DIMS-1:0][CW-1:0]            pt_q;
  logic [DIMS-1:0][CW-1:0]            nw_q;
  logic [DIMS-1:0][kmac_pkg::SQW-1:0] mvsq_q;
  logic [CIW-1:0]                     cid_q;
  logic [DIW:0]                       d_q;
  logic [5:0]                         tick_q;
  logic                               rec_q;

  // output register
  logic                               ov_q, olast_q;
  logic [3:0]                         oid_q;
  logic [kmac_pkg::MEASW-1:0]         omeas_q;
  logic [kmac_pkg::CNTW-1:0]          ocnt_q;
  logic [7:0][CW-1:0]                 ocoord_q;

  // cell row
  kmac_pkg::kmac_tok_t                 tok [CENTERS+1];
  logic [CENTERS-1:0][DIMS-1:0][CW-1:0] ctr;
  logic [CENTERS-1:0][DIMS-1:0][kmac_pkg::SUMW-1:0] sum;
  logic [CENTERS-1:0][kmac_pkg::CNTW-1:0] cnt;
  logic                                   accept;
  kmac_pkg::kmac_tok_t                    res_q;

  // load values, masked to COORD_BITS and scaled to Q10.6
  logic [DIMS-1:0][CW-1:0] pt_load;
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      logic [kmac_pkg::INW-1:0] m;
      m = raw_in[d] & kmac_pkg::INW'((32'd1 << COORD_BITS) - 1);
      pt_load[d] = CW'({m, {kmac_pkg::FRAC{1'b0}}});
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign accept     = in_valid_i && in_ready_o;

  // token enters at tick 1, once the cells' squares reflect the new point
  assign tok[0] = '{vld: (state_q == S_CLS) && (tick_q == 6'd1), best: '0, idx: '0};

  for (genvar c = 0; c < CENTERS; c++) begin : g_cell
    kmac_cell #(.DIMS(DIMS), .MAX_POINTS(MAX_POINTS), .MY_ID(c)) u_cell (
      .clk_i, .rst_ni,
      .load_i  (accept && kind_i == kmac_pkg::KIND_LOAD &&
                32'(center_slot_i) == c),
      .add_i   (state_q == S_ADD && res_q.idx == kmac_pkg::IDW'(c)),
      .upd_i   (state_q == S_RUPD && cid_q == CIW'(c) && cnt[c] != '0),
      .clr_i   (state_q == S_RUPD && cid_q == CIW'(c)),
      .new_i   ((state_q == S_IDLE) ? pt_load : nw_q),
      .pt_i    (pt_q),
      .raw_i   (raw_q),
      .tok_en_i(state_q == S_CLS),
      .tok_i   (tok[c]),
      .tok_o   (tok[c+1]),
      .ctr_o   (ctr[c]),
      .sum_o   (sum[c]),
      .cnt_o   (cnt[c])
    );
  end

  // shared divider
  logic                   div_done;
  logic [kmac_pkg::QW-1:0] div_q;
  logic [kmac_pkg::QW-1:0] div_num;
  assign div_num = kmac_pkg::QW'({sum[cid_q][d_q[DIW-1:0]], {kmac_pkg::FRAC{1'b0}}});

  kmac_div u_div (
    .clk_i, .rst_ni,
    .start_i(state_q == S_RDIV),
    .num_i  (div_num),
    .den_i  (cnt[cid_q]),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  logic [kmac_pkg::ACCW-1:0] mvacc;
  always_comb begin
    mvacc = '0;
    for (int d = 0; d < DIMS; d++) mvacc = mvacc + kmac_pkg::ACCW'(mvsq_q[d]);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) begin
        if (kind_i == kmac_pkg::KIND_LOAD)          state_d = S_EMIT;
        else if (kind_i == kmac_pkg::KIND_CLASSIFY) state_d = S_CLS;
        else if (kind_i == kmac_pkg::KIND_RECENTER) state_d = S_RDIV;
      end
      S_CLS:  if (tick_q == 6'(CENTERS + 1)) state_d = S_ADD;
      S_ADD:  state_d = S_EMIT;
      S_EMIT: if (!ov_q) state_d = rec_q ? S_RUPD : S_IDLE;
      S_RDIV: state_d = (cnt[cid_q] == '0) ? S_RSUM : S_RWT;
      S_RWT:  if (div_done) state_d = (32'(d_q) == DIMS - 1) ? S_RSQ : S_RDIV;
      S_RSQ:  state_d = S_RSUM;
      S_RSUM: state_d = S_EMIT;
      S_RUPD: state_d = (32'(cid_q) == CENTERS - 1) ? S_IDLE : S_RDIV;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tick_q  <= '0;
      cid_q   <= '0;
      d_q     <= '0;
      rec_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          tick_q <= '0;
          cid_q  <= '0;
          d_q    <= '0;
          rec_q  <= accept && kind_i == kmac_pkg::KIND_RECENTER;
          if (accept && kind_i == kmac_pkg::KIND_LOAD && 32'(center_slot_i) < CENTERS)
            ov_q <= 1'b1;
        end
        S_CLS:  tick_q <= tick_q + 1'b1;
        S_ADD:  ov_q <= 1'b1;
        S_RWT:  if (div_done) d_q <= d_q + 1'b1;
        S_RSUM: ov_q <= 1'b1;
        S_RUPD: begin
          cid_q <= cid_q + 1'b1;
          d_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int d = 0; d < DIMS; d++) begin
        raw_q[d] <= raw_in[d] & kmac_pkg::INW'((32'd1 << COORD_BITS) - 1);
        pt_q[d]  <= pt_load[d];
      end
      oid_q    <= center_slot_i;
      omeas_q  <= '0;
      olast_q  <= 1'b1;
      ocnt_q   <= cnt[center_slot_i[CIW-1:0]];
      ocoord_q <= pad_coords(pt_load);
    end
    if (state_q == S_CLS && tick_q == 6'(CENTERS + 1)) res_q <= tok[CENTERS];
    if (state_q == S_ADD) begin
      oid_q   <= kmac_pkg::IDW'(res_q.idx);
      omeas_q <= res_q.best;
      olast_q <= 1'b1;
      ocnt_q  <= (32'(cnt[res_q.idx[CIW-1:0]]) < MAX_POINTS) ?
                 cnt[res_q.idx[CIW-1:0]] + 1'b1 : cnt[res_q.idx[CIW-1:0]];
      ocoord_q <= pad_coords(ctr[res_q.idx[CIW-1:0]]);
    end
    if (state_q == S_RWT && div_done)
      nw_q[d_q[DIW-1:0]] <= (div_q > 32'hFFFF) ? 16'hFFFF : div_q[CW-1:0];
    if (state_q == S_RSQ) begin
      for (int d = 0; d < DIMS; d++) begin
        mvsq_q[d] <= (nw_q[d] > ctr[cid_q][d]) ?
          32'(nw_q[d] - ctr[cid_q][d]) * 32'(nw_q[d] - ctr[cid_q][d]) :
          32'(ctr[cid_q][d] - nw_q[d]) * 32'(ctr[cid_q][d] - nw_q[d]);
      end
    end
    if (state_q == S_RSUM) begin
      oid_q   <= kmac_pkg::IDW'(cid_q);
      omeas_q <= (cnt[cid_q] == '0) ? '0 :
                 (mvacc > kmac_pkg::ACCW'(kmac_pkg::MEAS_MAX)) ? kmac_pkg::MEAS_MAX :
                 mvacc[kmac_pkg::MEASW-1:0];
      ocnt_q  <= cnt[cid_q];
      olast_q <= (32'(cid_q) == CENTERS - 1);
      ocoord_q <= pad_coords((cnt[cid_q] == '0) ? ctr[cid_q] : nw_q);
    end
  end

  assign out_valid_o    = ov_q;
  assign center_id_o    = oid_q;
  assign measure_o      = omeas_q;
  assign member_count_o = ocnt_q;
  assign last_o         = olast_q;
  assign out_coord_0_o  = ocoord_q[0];
  assign out_coord_1_o  = ocoord_q[1];
  assign out_coord_2_o  = ocoord_q[2];
  assign out_coord_3_o  = ocoord_q[3];
  assign out_coord_4_o  = ocoord_q[4];
  assign out_coord_5_o  = ocoord_q[5];
  assign out_coord_6_o  = ocoord_q[6];
  assign out_coord_7_o  = ocoord_q[7];
endmodule

[src/kmac_checker.sv]
module kmac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [34:0] measure_o,
  input logic        last_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(measure_o) && $stable(last_o))
    else $error("result dropped under stall");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request taken while result pending");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("request withdrawn before it was taken");
endmodule

bind kmeans_assign_and_recenter_core kmac_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .measure_o, .last_o
);
